### design/assert_macros.svh
// Assertion macros shared by the RTL files of the beacon classifier.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising edge of clk_i, masked while rst_ni is low.
`define BBC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checked at every rising edge of clk_i, reset included.
`define BBC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

### design/bbc_pkg.sv
`default_nettype none

package bbc_pkg;

  // Bytes at this position of a payload and beyond are ignored.
  localparam int unsigned MAX_PAYLOAD_BYTES = 31;

  localparam logic [7:0] T_FLAGS        = 8'h01;
  localparam logic [7:0] T_UUID16_LIST  = 8'h03;
  localparam logic [7:0] T_SERVICE_DATA = 8'h16;
  localparam logic [7:0] T_MANUFACTURER = 8'hFF;
  localparam logic [7:0] FLAG_NO_BREDR  = 8'h04;
  localparam logic [15:0] COMPANY_ID    = 16'h004C;
  localparam logic [7:0] COMPANY_KIND   = 8'h02;
  localparam logic [15:0] SERVICE_ID    = 16'hFEAA;
  localparam logic [7:0] LONG_HDR_LEN   = 8'h1B;
  localparam logic [7:0] LONG_TOTAL_LEN = 8'h1C;
  localparam logic [15:0] LONG_CODE     = 16'hBEAC;
  localparam logic [7:0] FRAME_OFFSET   = 8'd11;

  // Payload positions checked for the long form.
  localparam logic [7:0] POS_HDR_LEN  = 8'd0;
  localparam logic [7:0] POS_HDR_TYPE = 8'd1;
  localparam logic [7:0] POS_CODE_LO  = 8'd4;
  localparam logic [7:0] POS_CODE_HI  = 8'd5;

  // Bit indexes of the structure match flags.
  localparam int unsigned M_FLAGS    = 0;
  localparam int unsigned M_COMPANY  = 1;
  localparam int unsigned M_UUIDLIST = 2;
  localparam int unsigned M_SVCDATA  = 3;

  // Bit indexes of the long-form check.
  localparam int unsigned L_HDR_LEN  = 0;
  localparam int unsigned L_HDR_TYPE = 1;
  localparam int unsigned L_CODE     = 2;

  // Structure offset saturates here: only the type and three data bytes matter.
  localparam logic [2:0] OFFSET_SAT = 3'd4;

  typedef enum logic [1:0] {
    CLASS_UNKNOWN = 2'd0,
    CLASS_COMPANY = 2'd1,
    CLASS_SERVICE = 2'd2,
    CLASS_LONG    = 2'd3
  } beacon_class_e;

  typedef struct packed {
    logic          valid;
    beacon_class_e beacon_class;
    logic [7:0]    frame_byte;
  } result_t;

endpackage

`default_nettype wire

### design/bbc_walker.sv
`default_nettype none

`include "assert_macros.svh"

module bbc_walker (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             take_i,
  input  wire logic [7:0]       adv_byte_i,
  input  wire logic             last_byte_i,
  output bbc_pkg::result_t      result_o
);

  logic [7:0] pos_q, pos_d;
  logic [7:0] left_q, left_d;
  logic [2:0] off_q, off_d;
  logic [7:0] type_q, type_d;
  logic [7:0] lead_q [3];
  logic [7:0] lead_d [3];
  logic [3:0] match_q, match_d;
  logic [2:0] lfc_q, lfc_d;
  logic [7:0] frame_q, frame_d;

  logic        in_range;
  logic        ends;
  logic        eval;
  logic [3:0]  hit;
  logic [15:0] id;
  logic [1:0]  lead_idx;

  assign in_range = pos_q < 8'(bbc_pkg::MAX_PAYLOAD_BYTES);
  assign lead_idx = off_q[1:0] - 2'd1;

  always_comb begin
    pos_d   = pos_q;
    left_d  = left_q;
    off_d   = off_q;
    type_d  = type_q;
    lead_d  = lead_q;
    lfc_d   = lfc_q;
    frame_d = frame_q;
    ends    = 1'b0;
    if (in_range) begin
      pos_d = pos_q + 8'd1;
      if (pos_q == bbc_pkg::POS_HDR_LEN && adv_byte_i == bbc_pkg::LONG_HDR_LEN) begin
        lfc_d[bbc_pkg::L_HDR_LEN] = 1'b1;
      end
      if (pos_q == bbc_pkg::POS_HDR_TYPE && adv_byte_i == bbc_pkg::T_MANUFACTURER) begin
        lfc_d[bbc_pkg::L_HDR_TYPE] = 1'b1;
      end
      if (pos_q == bbc_pkg::POS_CODE_LO && adv_byte_i == bbc_pkg::LONG_CODE[7:0]) begin
        lfc_d[bbc_pkg::L_CODE] = 1'b1;
      end
      if (pos_q == bbc_pkg::POS_CODE_HI && adv_byte_i != bbc_pkg::LONG_CODE[15:8]) begin
        lfc_d[bbc_pkg::L_CODE] = 1'b0;
      end
      if (pos_q == bbc_pkg::FRAME_OFFSET) begin
        frame_d = adv_byte_i;
      end

      if (left_q == 8'd0) begin
        // A zero length byte opens nothing and is simply skipped.
        if (adv_byte_i != 8'd0) begin
          left_d = adv_byte_i;
          off_d  = 3'd0;
          type_d = 8'd0;
          lead_d = '{default: 8'd0};
        end
      end else begin
        if (off_q == 3'd0) begin
          type_d = adv_byte_i;
        end else if (off_q != bbc_pkg::OFFSET_SAT) begin
          lead_d[lead_idx] = adv_byte_i;
        end
        off_d  = (off_q == bbc_pkg::OFFSET_SAT) ? off_q : off_q + 3'd1;
        left_d = left_q - 8'd1;
        ends   = (left_d == 8'd0);
      end
    end
  end

  // A structure is judged when it closes, or when the payload ends inside it.
  assign eval = ends || (last_byte_i && left_d != 8'd0);
  assign id   = {lead_d[1], lead_d[0]};

  always_comb begin
    hit = 4'd0;
    unique case (type_d)
      bbc_pkg::T_FLAGS: begin
        hit[bbc_pkg::M_FLAGS] = (lead_d[0] & bbc_pkg::FLAG_NO_BREDR) != 8'd0;
      end
      bbc_pkg::T_MANUFACTURER: begin
        hit[bbc_pkg::M_COMPANY] = (id == bbc_pkg::COMPANY_ID)
                                  && (lead_d[2] == bbc_pkg::COMPANY_KIND);
      end
      bbc_pkg::T_UUID16_LIST: begin
        hit[bbc_pkg::M_UUIDLIST] = (id == bbc_pkg::SERVICE_ID);
      end
      bbc_pkg::T_SERVICE_DATA: begin
        hit[bbc_pkg::M_SVCDATA] = (id == bbc_pkg::SERVICE_ID);
      end
      default: begin
        hit = 4'd0;
      end
    endcase
  end

  assign match_d = match_q | (eval ? hit : 4'd0);

  always_comb begin
    result_o.valid      = take_i && last_byte_i;
    result_o.frame_byte = frame_d;
    if (match_d[bbc_pkg::M_FLAGS] && match_d[bbc_pkg::M_COMPANY]) begin
      result_o.beacon_class = bbc_pkg::CLASS_COMPANY;
    end else if (match_d[bbc_pkg::M_UUIDLIST] && match_d[bbc_pkg::M_SVCDATA]) begin
      result_o.beacon_class = bbc_pkg::CLASS_SERVICE;
    end else if (pos_d == bbc_pkg::LONG_TOTAL_LEN && lfc_d == 3'b111) begin
      result_o.beacon_class = bbc_pkg::CLASS_LONG;
    end else begin
      result_o.beacon_class = bbc_pkg::CLASS_UNKNOWN;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= 8'd0;
      left_q  <= 8'd0;
      off_q   <= 3'd0;
      match_q <= 4'd0;
      lfc_q   <= 3'd0;
      frame_q <= 8'd0;
    end else if (take_i) begin
      if (last_byte_i) begin
        pos_q   <= 8'd0;
        left_q  <= 8'd0;
        off_q   <= 3'd0;
        match_q <= 4'd0;
        lfc_q   <= 3'd0;
        frame_q <= 8'd0;
      end else begin
        pos_q   <= pos_d;
        left_q  <= left_d;
        off_q   <= off_d;
        match_q <= match_d;
        lfc_q   <= lfc_d;
        frame_q <= frame_d;
      end
    end
  end

  // Type and leading bytes are cleared at every structure start before use.
  always_ff @(posedge clk_i) begin
    if (take_i) begin
      type_q <= type_d;
      lead_q <= lead_d;
    end
  end

  `BBC_ASSERT(a_pos_bound, pos_q <= 8'(bbc_pkg::MAX_PAYLOAD_BYTES), "byte position overran")
  `BBC_ASSERT(a_restart, (take_i && last_byte_i) |=> (pos_q == 8'd0 && left_q == 8'd0 && match_q == 4'd0), "walker not cleared after last byte")
  `BBC_ASSERT(a_off_sat, off_q <= bbc_pkg::OFFSET_SAT, "structure offset past saturation")

endmodule

`default_nettype wire

### design/ble_beacon_type_classifier_top.sv
// Beacon classifier: feed the bytes of one advertising payload in order, one
// transfer per byte, with last_byte_i set on the final byte. The block walks
// the length-type-data structures and delivers exactly one result per payload,
// the beacon class and the payload byte at offset 11 (zero for shorter
// payloads), as one output transfer. A byte is taken in every unstalled cycle:
// the whole per-byte step is a handful of compares between the walker registers
// and the result register, so the sustained rate is one byte per clock while
// unstalled, and the result appears on the outputs in the cycle after the
// transfer of the last byte. The input stalls only while a result sits in the
// output register and the downstream side stalls it; a finished result then
// waits there while no further byte is taken. Bytes beyond the payload limit
// are ignored, though a last-byte mark on them still closes the payload.
`default_nettype none

`include "assert_macros.svh"

module ble_beacon_type_classifier_top (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic [7:0] adv_byte_i,
  input  wire logic       last_byte_i,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output logic [1:0]      beacon_class_o,
  output logic [7:0]      frame_byte_o
);

  logic                 take;
  bbc_pkg::result_t     result;
  logic                 out_valid_q, out_valid_d;
  bbc_pkg::beacon_class_e class_q;
  logic [7:0]           frame_q;

  // The output register is the only thing that can hold the input back.
  assign in_stall_o = out_valid_q && out_stall_i;
  assign take       = in_valid_i && !in_stall_o;

  bbc_walker u_walker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .take_i      (take),
    .adv_byte_i  (adv_byte_i),
    .last_byte_i (last_byte_i),
    .result_o    (result)
  );

  always_comb begin
    priority if (result.valid) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // A new result is loaded only when the register is empty or being drained.
  always_ff @(posedge clk_i) begin
    if (result.valid) begin
      class_q <= result.beacon_class;
      frame_q <= result.frame_byte;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign beacon_class_o = class_q;
  assign frame_byte_o   = frame_q;

  `BBC_ASSERT(a_result_source, $rose(out_valid_o) |-> $past(in_valid_i && !in_stall_o && last_byte_i), "result without a last byte")
  `BBC_ASSERT(a_result_drain, (out_valid_o && !out_stall_i && !(in_valid_i && last_byte_i)) |=> !out_valid_o, "result delivered twice")
  `BBC_ASSERT_ALWAYS(a_reset_empty, !rst_ni |-> !out_valid_o, "output valid during reset")

endmodule

`default_nettype wire
